### rtl/pic_pkg.sv
package pic_pkg;

    localparam int MAX_VERTICES_DEF = 16;
    localparam int COORD_W          = 16;
    localparam int DIFF_W           = COORD_W + 1;
    localparam int PROD_W           = 2 * DIFF_W;
    localparam int CFG_W            = 5;
    localparam int SLOT_W           = 4;
    localparam int S_TDATA_W        = 40;
    localparam int M_TDATA_W        = 8;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TEST  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vertex;

    // tag that travels with one vertex read
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_rd_tag;

endpackage

### rtl/pic_vstore.sv
module pic_vstore #(
    parameter int DEPTH = pic_pkg::MAX_VERTICES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  pic_pkg::t_vertex i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output pic_pkg::t_vertex o_rdata
);
    import pic_pkg::*;

    t_vertex r_mem [DEPTH];
    t_vertex r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/pic_cross.sv
module pic_cross (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic signed [pic_pkg::COORD_W-1:0] i_px,
    input  logic signed [pic_pkg::COORD_W-1:0] i_py,
    input  pic_pkg::t_rd_tag                   i_rd,
    input  pic_pkg::t_vertex                   i_vtx,
    output logic                               o_done,
    output logic                               o_inside
);
    import pic_pkg::*;

    function automatic logic signed [DIFF_W-1:0] sx(input logic [COORD_W-1:0] v);
        return {v[COORD_W-1], v};
    endfunction

    t_vertex r_v0;
    t_vertex r_prev;
    logic    r_close;

    logic                     r_s1_valid;
    logic                     r_s1_last;
    logic signed [DIFF_W-1:0] r_dx;
    logic signed [DIFF_W-1:0] r_dy;
    logic signed [DIFF_W-1:0] r_qx;
    logic signed [DIFF_W-1:0] r_qy;

    logic                     r_s2_valid;
    logic                     r_s2_last;
    logic signed [PROD_W-1:0] r_p1;
    logic signed [PROD_W-1:0] r_p2;

    logic r_any_neg;
    logic r_done;
    logic r_inside;

    t_vertex edge_b;
    logic    edge_go;
    logic    neg;

    // closing edge runs from the last vertex back to vertex 0
    always_comb begin
        edge_b  = r_close ? r_v0 : i_vtx;
        edge_go = (i_rd.valid && !i_rd.first) || r_close;
        neg     = r_p1 < r_p2;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.valid) begin
            r_prev <= i_vtx;
            if (i_rd.first) begin
                r_v0 <= i_vtx;
            end
        end
        r_dx <= sx(edge_b.x) - sx(r_prev.x);
        r_dy <= sx(edge_b.y) - sx(r_prev.y);
        r_qx <= sx(i_px) - sx(r_prev.x);
        r_qy <= sx(i_py) - sx(r_prev.y);
        r_p1 <= PROD_W'(r_dx) * PROD_W'(r_qy);
        r_p2 <= PROD_W'(r_dy) * PROD_W'(r_qx);
        r_inside <= !(r_any_neg || neg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_close    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s2_last  <= 1'b0;
            r_any_neg  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_close    <= i_rd.valid && i_rd.last;
            r_s1_valid <= edge_go;
            r_s1_last  <= r_close;
            r_s2_valid <= r_s1_valid;
            r_s2_last  <= r_s1_last;
            r_done     <= r_s2_valid && r_s2_last;
            if (r_s2_valid) begin
                r_any_neg <= r_s2_last ? 1'b0 : (r_any_neg || neg);
            end
        end
    end

    assign o_done   = r_done;
    assign o_inside = r_inside;

endmodule

### rtl/point_in_convex_polygon.sv
// Point-in-convex-polygon test.
// Input stream s_axis: tuser selects the request. A write word stores one
// vertex (x, y) at slot vertex_slot; slots at or above MAX_VERTICES are
// dropped. A test word carries a point and yields one result word on
// m_axis: bit 0 is 1 when no edge cross product is negative.
// i_cfg_we / i_cfg_wdata set the vertex count, saturated to MAX_VERTICES.
// Writes are accepted back to back. A test with n vertices (n after
// saturation) holds s_axis_tready low until its result is loaded into the
// result register; n = 0 gives inside without a memory read, and otherwise
// the vertex memory read port gives one edge per cycle, followed by a
// three stage difference / multiply / compare pipeline.
// One result register feeds m_axis; a stalled receiver keeps it, and the
// next test is accepted but holds its own result until the register frees.
// Reset clears the vertex count, the sequencer and the output valid;
// vertex memory contents are undefined until written.
module point_in_convex_polygon #(
    parameter int MAX_VERTICES = pic_pkg::MAX_VERTICES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pic_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] vertex_slot, [19:4] coord_x, [35:20] coord_y, [39:36] zero
    input  logic [pic_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [0] req_type
    input  logic                            s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [0] inside_res, [7:1] zero
    output logic [pic_pkg::M_TDATA_W-1:0]   m_axis_tdata
);
    import pic_pkg::*;

    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int CW  = $clog2(MAX_VERTICES + 1);
    localparam int NW  = (CW > CFG_W) ? CW : CFG_W;
    localparam int SW  = (CW > SLOT_W) ? CW : SLOT_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_OUT
    } t_state;

    t_state               r_state;
    logic [CFG_W-1:0]     r_cfg;
    logic [AW-1:0]        r_addr;
    logic [AW-1:0]        r_last_addr;
    logic signed [COORD_W-1:0] r_px;
    logic signed [COORD_W-1:0] r_py;
    logic                 r_inside;
    logic                 r_out_valid;
    logic                 r_out_inside;
    t_rd_tag              r_rd;

    logic [SLOT_W-1:0]    in_slot;
    t_vertex              in_vtx;
    logic                 accept;
    logic [NW-1:0]        cnt;
    logic                 slot_ok;
    logic                 mem_we;
    logic                 mem_re;
    t_vertex              mem_rdata;
    logic                 out_free;
    logic                 done;
    logic                 done_inside;

    always_comb begin
        in_slot  = s_axis_tdata[SLOT_W-1:0];
        in_vtx.x = s_axis_tdata[SLOT_W +: COORD_W];
        in_vtx.y = s_axis_tdata[SLOT_W+COORD_W +: COORD_W];
        accept   = s_axis_tvalid && s_axis_tready;
        cnt      = (NW'(r_cfg) > NW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(r_cfg);
        slot_ok  = SW'(in_slot) < SW'(MAX_VERTICES);
        mem_we   = accept && (s_axis_tuser == REQ_WRITE) && slot_ok;
        mem_re   = (r_state == ST_READ);
        out_free = !r_out_valid || m_axis_tready;
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_inside};

    pic_vstore #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_vstore (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (AW'(in_slot)),
        .i_wdata (in_vtx),
        .i_re    (mem_re),
        .i_raddr (r_addr),
        .o_rdata (mem_rdata)
    );

    pic_cross u_cross (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_px     (r_px),
        .i_py     (r_py),
        .i_rd     (r_rd),
        .i_vtx    (mem_rdata),
        .o_done   (done),
        .o_inside (done_inside)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg       <= '0;
            r_addr      <= '0;
            r_rd        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_rd.valid <= mem_re;
            r_rd.first <= (r_addr == '0);
            r_rd.last  <= (r_addr == r_last_addr);
            // ST_OUT reloads the register itself
            if (r_out_valid && m_axis_tready && (r_state != ST_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (accept && (s_axis_tuser == REQ_TEST)) begin
                        r_px        <= in_vtx.x;
                        r_py        <= in_vtx.y;
                        r_addr      <= '0;
                        r_last_addr <= AW'(cnt - NW'(1));
                        if (cnt == '0) begin
                            r_inside <= 1'b1;
                            r_state  <= ST_OUT;
                        end else begin
                            r_state <= ST_READ;
                        end
                    end
                end
                ST_READ: begin
                    if (r_addr == r_last_addr) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                ST_DRAIN: begin
                    if (done) begin
                        r_inside <= done_inside;
                        r_state  <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_inside <= r_inside;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

### verif/tb_point_in_convex_polygon.sv
`timescale 1ns / 100ps

module tb_point_in_convex_polygon;
    import pic_pkg::*;

    localparam int  MAXV           = MAX_VERTICES_DEF;
    localparam int  TARGET_WORDS   = 1800;
    localparam int  SETTLE_CYCLES  = 32;
    localparam int  LONG_HOLD      = 400;
    localparam int  WATCHDOG_LIMIT = 3000;
    localparam real TWO_PI         = 6.283185307179586;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} t_rx_mode;

    class t_hit_scoreboard;
        t_vertex          corners[MAXV];
        logic [CFG_W-1:0] vertex_count;
        bit               inside_q[$];
        int               errors;

        function new();
            vertex_count = '0;
            errors = 0;
            foreach (corners[i]) corners[i] = '0;
        endfunction

        function void set_count(input logic [CFG_W-1:0] n);
            vertex_count = n;
        endfunction

        // exact edge cross products, outside on the first negative one
        function bit point_covered(input longint px, input longint py);
            int     n, i, j;
            longint x1, y1, x2, y2, xprod;
            n = (vertex_count > MAXV) ? MAXV : int'(vertex_count);
            for (i = 0; i < n; i++) begin
                j = (i + 1 == n) ? 0 : i + 1;
                x1 = corners[i].x;
                y1 = corners[i].y;
                x2 = corners[j].x;
                y2 = corners[j].y;
                xprod = (x2 - x1) * (py - y1) - (y2 - y1) * (px - x1);
                if (xprod < 0) return 1'b0;
            end
            return 1'b1;
        endfunction

        function void note_word(input logic req, input logic [SLOT_W-1:0] slot,
                                input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
            if (req == REQ_WRITE) begin
                if (slot < MAXV) corners[slot] = {y, x};
            end else begin
                inside_q.push_back(point_covered(x, y));
            end
        endfunction

        function void check_result(input logic [M_TDATA_W-1:0] word);
            bit exp_inside;
            if (inside_q.size() == 0) begin
                errors++;
                $display("%0t ERROR unexpected result word: expected none, actual %h",
                         $time, word);
                return;
            end
            exp_inside = inside_q.pop_front();
            if (word[0] !== exp_inside) begin
                errors++;
                $display("%0t ERROR inside_res: expected %0d, actual %b",
                         $time, exp_inside, word[0]);
            end
            if (word[M_TDATA_W-1:1] !== '0) begin
                errors++;
                $display("%0t ERROR tdata pad: expected 0, actual %h",
                         $time, word[M_TDATA_W-1:1]);
            end
        endfunction

        function int pending();
            return inside_q.size();
        endfunction
    endclass

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]     i_cfg_wdata   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
    logic                 s_axis_tuser  = REQ_WRITE;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;

    t_hit_scoreboard sb = new();
    int  words_sent    = 0;
    int  burst_left    = 0;
    bit  steady_send   = 1'b1;
    bit  long_hold_req = 1'b0;
    int  quiet_cycles  = 0;

    point_in_convex_polygon dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ERROR watchdog: no word moved for %0d cycles", $time, quiet_cycles);
            $display("Regression FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side ready pacing
    initial begin : rx_pace
        t_rx_mode mode;
        int       span, k;
        forever begin
            mode = t_rx_mode'($urandom_range(0, 3));
            span = $urandom_range(16, 160);
            for (k = 0; k < span; k++) begin
                @(posedge i_clk);
                if (long_hold_req) begin
                    long_hold_req = 1'b0;
                    m_axis_tready <= 1'b0;
                    repeat (LONG_HOLD) @(posedge i_clk);
                end
                case (mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_COIN:    m_axis_tready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: m_axis_tready <= ((k % 7) < 3);
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    function automatic logic signed [COORD_W-1:0] clamp16(input longint v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return COORD_W'(v);
    endfunction

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    task automatic push_word(input logic req, input logic [SLOT_W-1:0] slot,
                             input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        if (!steady_send && burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 16);
        end
        if (burst_left != 0) burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req;
        s_axis_tdata  <= {4'b0000, y, x, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(req, slot, x, y);
        words_sent++;
    endtask

    // stop sending, wait for every result, then let the pipe go quiet
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [CFG_W-1:0] n);
        quiesce();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_count(n);
    endtask

    task automatic test_point(input longint x, input longint y);
        push_word(REQ_TEST, SLOT_W'($urandom_range(0, 15)), clamp16(x), clamp16(y));
    endtask

    task automatic run_polygon_phase(input int phase_idx);
        int                         n, m, k, j, tests, pick, span;
        bit                         cw, scramble;
        real                        r, base, ang;
        longint                     cx, cy;
        logic signed [COORD_W-1:0]  px_v[MAXV];
        logic signed [COORD_W-1:0]  py_v[MAXV];
        case (phase_idx)
            0: n = 31;
            1: n = 16;
            2: n = 0;
            3: n = 1;
            4: n = 16;
            default: begin
                pick = $urandom_range(0, 9);
                if (pick < 3)      n = $urandom_range(3, 8);
                else if (pick < 6) n = $urandom_range(9, 16);
                else if (pick < 8) n = $urandom_range(17, 31);
                else               n = $urandom_range(0, 2);
            end
        endcase
        m = (n > MAXV) ? MAXV : n;
        steady_send = ($urandom_range(0, 3) == 0);
        cw       = ($urandom_range(0, 4) == 0);
        scramble = ($urandom_range(0, 9) == 0);
        cx = rand_span(16000);
        cy = rand_span(16000);
        pick = $urandom_range(0, 5);
        if (pick == 0)      r = $urandom_range(1, 40);
        else if (pick == 1) r = 40000.0;
        else                r = $urandom_range(100, 16000);
        base = $urandom_range(0, 1000) / 1000.0 * TWO_PI;

        for (k = 0; k < m; k++) begin
            ang = base + (k + 0.8 * ($urandom_range(0, 1000) / 1000.0)) * TWO_PI / m;
            j = cw ? m - 1 - k : k;
            if (scramble) begin
                px_v[j] = COORD_W'($urandom());
                py_v[j] = COORD_W'($urandom());
            end else begin
                px_v[j] = clamp16(cx + longint'($rtoi(r * $cos(ang))));
                py_v[j] = clamp16(cy + longint'($rtoi(r * $sin(ang))));
            end
        end
        for (k = 0; k < m; k++) push_word(REQ_WRITE, SLOT_W'(k), px_v[k], py_v[k]);
        set_vertex_count(CFG_W'(n));

        tests = $urandom_range(10, 50);
        if (phase_idx == 4) begin
            tests = 40;
            steady_send = 1'b1;
            long_hold_req = 1'b1;
        end
        span = (r / 2 > 32767.0) ? 32767 : $rtoi(r / 2) + 1;
        for (k = 0; k < tests; k++) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                push_word(REQ_WRITE, SLOT_W'($urandom()), COORD_W'($urandom()),
                          COORD_W'($urandom()));
            end else if (pick < 9 || m == 0) begin
                test_point(cx + rand_span(span), cy + rand_span(span));
            end else if (pick < 12) begin
                j = $urandom_range(0, m - 1);
                test_point(px_v[j], py_v[j]);
            end else if (pick < 14) begin
                j = $urandom_range(0, m - 1);
                test_point((longint'(px_v[j]) + px_v[(j + 1) % m]) / 2,
                           (longint'(py_v[j]) + py_v[(j + 1) % m]) / 2);
            end else if (pick < 18) begin
                push_word(REQ_TEST, SLOT_W'($urandom()), COORD_W'($urandom()),
                          COORD_W'($urandom()));
            end else begin
                test_point(($urandom_range(0, 1) != 0) ? 32767 : -32768,
                           ($urandom_range(0, 2) == 0) ? 0 :
                           (($urandom_range(0, 1) != 0) ? 32767 : -32768));
            end
        end
    endtask

    initial begin : stimulus
        int phase_idx;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // no vertices: always inside
        steady_send = 1'b1;
        push_word(REQ_TEST, 4'h0, 16'h8000, 16'h8000);
        push_word(REQ_TEST, 4'hF, 16'h7FFF, 16'h7FFF);

        // single vertex: degenerate edge
        push_word(REQ_WRITE, 4'h0, 16'h7FFF, 16'h8000);
        set_vertex_count(CFG_W'(1));
        test_point(0, 0);
        test_point(-32768, 32767);

        // two vertices: inside only on the line
        push_word(REQ_WRITE, 4'h1, 16'h7FFF, 16'h7FFF);
        push_word(REQ_WRITE, 4'h2, 16'h8000, 16'h7FFF);
        set_vertex_count(CFG_W'(2));
        test_point(32767, 0);
        test_point(0, 0);

        // full-range triangle
        set_vertex_count(CFG_W'(3));
        test_point(0, 0);
        test_point(-32768, -32768);
        test_point(32767, 32767);
        test_point(0, 32767);
        test_point(-32768, 32767);
        test_point(32767, -32768);
        push_word(REQ_WRITE, 4'hF, 16'hFFFF, 16'hFFFF);
        test_point(1, 1);
        test_point(-1, 0);

        phase_idx = 0;
        while (words_sent < TARGET_WORDS) begin
            run_polygon_phase(phase_idx);
            phase_idx++;
        end

        quiesce();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
